### design/rssi_channel_scan_macros.svh
// ---------------------------------------------------------------------------
// rssi channel scan assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef RSSI_CHANNEL_SCAN_MACROS_SVH
`define RSSI_CHANNEL_SCAN_MACROS_SVH

`ifndef SYNTH

// antecedent holds, consequent in the next cycle
`define RCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rssi_channel_scan: check failed");

// antecedent holds, consequent in the same cycle
`define RCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rssi_channel_scan: check failed");

`else

`define RCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define RCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/rcs_pkg.sv
// ---------------------------------------------------------------------------
// rcs_pkg
// shared types and constants of the rssi channel scan
// ---------------------------------------------------------------------------
package rcs_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [7:0] RSSI_FAILED = 8'hFF;

  // commands
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_START     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOWER     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rssi;
    logic       reading_failed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tune_channel;
    logic       scanning;
    logic       finished;
    logic [7:0] chosen_channel;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_channel;
    logic [7:0] upper_channel;
    logic [7:0] lower_channel;
    logic [7:0] rssi_threshold;
  } cfg_t;

  typedef struct packed {
    logic             active;
    logic             going_up;
    logic [7:0]       current_channel;
    logic [CNT_W-1:0] sample_count;
    logic [7:0]       least_rssi;
    logic [7:0]       least_channel;
  } scan_state_t;

endpackage

### design/rcs_step.sv
// ---------------------------------------------------------------------------
// rcs_step
// next scan state and result for one item
// ---------------------------------------------------------------------------
module rcs_step (
  input  rcs_pkg::scan_state_t cur,
  input  rcs_pkg::cfg_t        cfg,
  input  rcs_pkg::in_item_t    item,
  output rcs_pkg::scan_state_t nxt,
  output rcs_pkg::out_item_t   res
);
  import rcs_pkg::*;

  logic [7:0]       level;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       least_rssi_upd;
  logic [7:0]       least_chan_upd;
  logic             going_up_upd;
  logic [7:0]       chan_upd;

  always_comb begin
    level = item.reading_failed ? RSSI_FAILED : item.rssi;

    // running minimum, earliest wins on a tie
    least_rssi_upd = cur.least_rssi;
    least_chan_upd = cur.least_channel;
    cnt_inc        = cur.sample_count;
    if (cur.sample_count < CNT_W'(MAX_SAMPLES)) begin
      if ((cur.sample_count == '0) || (level < cur.least_rssi)) begin
        least_rssi_upd = level;
        least_chan_upd = cur.current_channel;
      end
      cnt_inc = cur.sample_count + CNT_W'(1);
    end

    // sweep up, then from the start channel down
    going_up_upd = cur.going_up;
    chan_upd     = cur.current_channel;
    if (cur.going_up) begin
      if (cur.current_channel < cfg.upper_channel) begin
        chan_upd = cur.current_channel + 8'd1;
      end else if (cur.current_channel == cfg.upper_channel) begin
        going_up_upd = 1'b0;
        chan_upd     = cfg.start_channel;
      end
    end

    nxt = cur;
    res = '{tune_channel: cur.current_channel, scanning: 1'b0,
            finished: 1'b0, chosen_channel: 8'd0};

    if (item.cmd == CMD_START) begin
      nxt.active          = 1'b1;
      nxt.going_up        = 1'b1;
      nxt.sample_count    = '0;
      nxt.least_rssi      = RSSI_FAILED;
      nxt.current_channel = cfg.start_channel;
      nxt.least_channel   = cfg.start_channel;
      res.tune_channel    = cfg.start_channel;
      res.scanning        = 1'b1;
    end else if (cur.active) begin
      if (level < cfg.rssi_threshold) begin
        // early pick of the current channel
        nxt.active         = 1'b0;
        nxt.going_up       = 1'b1;
        res.tune_channel   = cur.current_channel;
        res.finished       = 1'b1;
        res.chosen_channel = cur.current_channel;
      end else begin
        nxt.least_rssi    = least_rssi_upd;
        nxt.least_channel = least_chan_upd;
        nxt.sample_count  = cnt_inc;
        if (cnt_inc >= CNT_W'(MAX_SAMPLES)) begin
          nxt.active         = 1'b0;
          nxt.going_up       = 1'b1;
          res.tune_channel   = least_chan_upd;
          res.finished       = 1'b1;
          res.chosen_channel = least_chan_upd;
        end else begin
          nxt.current_channel = chan_upd;
          nxt.going_up        = going_up_upd;
          res.tune_channel    = chan_upd;
          res.scanning        = 1'b1;
          if (!going_up_upd) begin
            if (cfg.lower_channel < chan_upd) begin
              nxt.current_channel = chan_upd - 8'd1;
              res.tune_channel    = chan_upd - 8'd1;
            end else if (cfg.lower_channel == chan_upd) begin
              nxt.active         = 1'b0;
              nxt.going_up       = 1'b1;
              res.tune_channel   = least_chan_upd;
              res.scanning       = 1'b0;
              res.finished       = 1'b1;
              res.chosen_channel = least_chan_upd;
            end
          end
        end
      end
    end
  end

endmodule

### design/rssi_channel_scan.sv
// result: the result of an item is registered and presented in the cycle after it is accepted
// throughput: one item per cycle while out_ready holds; the next-state logic of rcs_step is
//   combinational and the output register lets input and output run in parallel
// reset (rst_n low, synchronous): scan idle, sweep direction up, channel 0,
//   empty sample store, configuration registers 0, no result pending
// ---------------------------------------------------------------------------
// rssi_channel_scan
// channel scan with early threshold pick and running minimum over samples
// ---------------------------------------------------------------------------
`include "rssi_channel_scan_macros.svh"

module rssi_channel_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [rcs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // command and measurement items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rcs_pkg::in_item_t             in_data,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output rcs_pkg::out_item_t            out_data
);
  import rcs_pkg::*;

  // configuration registers
  cfg_t        cfg_r;

  // scan state, updated as each item is accepted
  scan_state_t state_r;
  scan_state_t state_nxt;

  // result register
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   res_nxt;

  logic        in_fire;

  // take a new item whenever the result register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  rcs_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (in_data),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // register file, writes land at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START:     cfg_r.start_channel  <= cfg_wdata;
        REG_UPPER:     cfg_r.upper_channel  <= cfg_wdata;
        REG_LOWER:     cfg_r.lower_channel  <= cfg_wdata;
        REG_THRESHOLD: cfg_r.rssi_threshold <= cfg_wdata;
        default:       cfg_r                <= cfg_r;
      endcase
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{active: 1'b0, going_up: 1'b1, current_channel: 8'd0,
                   sample_count: '0, least_rssi: RSSI_FAILED, least_channel: 8'd0};
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output stage: valid is control, payload loads on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every accepted item yields a result next cycle
  `RCS_ASSERT_NEXT(a_item_gives_result, clk, rst_n, in_fire, out_valid_r)
  // a finishing item leaves the scan idle
  `RCS_ASSERT_NEXT(a_finish_goes_idle, clk, rst_n, in_fire && res_nxt.finished,
                   !state_r.active && state_r.going_up)
  // a start item opens a fresh scan
  `RCS_ASSERT_NEXT(a_start_opens_scan, clk, rst_n,
                   in_fire && (in_data.cmd == CMD_START),
                   state_r.active && (state_r.sample_count == '0))
  // sample store never overfills
  `RCS_ASSERT_SAME(a_count_bound, clk, rst_n, state_r.active,
                   state_r.sample_count < CNT_W'(MAX_SAMPLES))
  // a result held back keeps its payload
  `RCS_ASSERT_NEXT(a_held_result, clk, rst_n, out_valid_r && !out_ready,
                   out_valid_r && $stable(out_data_r))

endmodule

### tb/tb_rssi_channel_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rssi_channel_scan
// self-checking bench for the channel scan: a short table of directed items,
// then random scans under several register settings, every result checked
// against a table value or a cycle-free model of the sweep and the running minimum
// ---------------------------------------------------------------------------
module tb_rssi_channel_scan;
  import rcs_pkg::*;

  // watchdog limit: longest hold-off plus the longest gaps, several times over
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 250;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 4;
  localparam int N_CORNERS    = 6;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_FIXED} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_t      regs;
    in_item_t  item;
    out_item_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  rssi_channel_scan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---- model of the scan: register copy and sweep state ----
  cfg_t       scan_regs  = '0;
  logic       scan_on    = 1'b0;
  logic       sweep_up   = 1'b1;
  logic [7:0] cur_chan   = 8'd0;
  int         n_samples  = 0;
  logic [7:0] best_rssi  = RSSI_FAILED;
  logic [7:0] best_chan  = 8'd0;

  out_item_t  result_q[$];   // expected results, oldest first
  plan_row_t  plan_q[$];     // directed table

  int errors        = 0;
  int items_sent    = 0;
  int live_items    = 0;     // items the block acts on (idle measurements left out)
  int results_seen  = 0;
  int scans_done    = 0;
  int early_picks   = 0;
  int stall_cycles  = 0;
  bit held_once     = 1'b0;
  bit fast_phase    = 1'b0;

  // scan over: back to idle, direction reset to up, pick reported on both fields
  function automatic out_item_t end_scan(logic [7:0] pick);
    scan_on  = 1'b0;
    sweep_up = 1'b1;
    return out_item_t'{pick, 1'b0, 1'b1, pick};
  endfunction

  // advance the scan by one item and give the result it causes
  function automatic out_item_t predict_scan(in_item_t it);
    logic [7:0] level;
    if (it.cmd == CMD_START) begin
      // start, also while scanning: restart from the start channel
      scan_on   = 1'b1;
      sweep_up  = 1'b1;
      n_samples = 0;
      best_rssi = RSSI_FAILED;
      cur_chan  = scan_regs.start_channel;
      best_chan = scan_regs.start_channel;
      return out_item_t'{cur_chan, 1'b1, 1'b0, 8'd0};
    end
    // measurement while idle is dropped
    if (!scan_on) return out_item_t'{cur_chan, 1'b0, 1'b0, 8'd0};
    level = it.reading_failed ? RSSI_FAILED : it.rssi;
    // strictly below threshold: take this channel now
    if (level < scan_regs.rssi_threshold) begin
      early_picks++;
      return end_scan(cur_chan);
    end
    // running minimum keeps the earliest channel on ties
    if (n_samples < MAX_SAMPLES) begin
      if (n_samples == 0 || level < best_rssi) begin
        best_rssi = level;
        best_chan = cur_chan;
      end
      n_samples++;
    end
    if (n_samples >= MAX_SAMPLES) return end_scan(best_chan);
    // upward sweep; out of bounds the channel stays put
    if (sweep_up) begin
      if (cur_chan < scan_regs.upper_channel) begin
        cur_chan = cur_chan + 8'd1;
      end else if (cur_chan == scan_regs.upper_channel) begin
        sweep_up = 1'b0;
        cur_chan = scan_regs.start_channel;
      end
    end
    // downward sweep, entered in the same item as the jump back
    if (!sweep_up) begin
      if (scan_regs.lower_channel < cur_chan) begin
        cur_chan = cur_chan - 8'd1;
      end else if (scan_regs.lower_channel == cur_chan) begin
        return end_scan(best_chan);
      end
    end
    return out_item_t'{cur_chan, 1'b1, 1'b0, 8'd0};
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_item_t start_item();
    in_item_t it;
    it.cmd            = CMD_START;
    it.rssi           = 8'($urandom_range(0, 255));  // don't care, toggled anyway
    it.reading_failed = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t measure_item();
    in_item_t it;
    int       lvl;
    it.cmd = CMD_MEASURE;
    if ($urandom_range(0, 3) == 0) begin
      // land near the threshold to work both sides of the compare
      lvl = int'(scan_regs.rssi_threshold) + int'($urandom_range(0, 6)) - 3;
      if (lvl < 0) lvl = 0;
      if (lvl > 255) lvl = 255;
      it.rssi = lvl[7:0];
    end else begin
      it.rssi = 8'($urandom_range(0, 255));
    end
    it.reading_failed = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // window around the start channel so the sweep turns within the store size
  function automatic cfg_t random_regs();
    cfg_t r;
    int   s;
    int   up;
    int   pick;
    if ($urandom_range(0, 5) == 0) begin
      r.start_channel = 8'($urandom_range(0, 255));
      r.upper_channel = 8'($urandom_range(0, 255));
      r.lower_channel = 8'($urandom_range(0, 255));
    end else begin
      s  = int'($urandom_range(0, 255));
      up = s + int'($urandom_range(0, 8));
      r.start_channel = 8'(s);
      r.upper_channel = (up > 255) ? 8'hFF : 8'(up);
      r.lower_channel = (s < 8) ? 8'($urandom_range(0, s))
                                : 8'(s - int'($urandom_range(0, 8)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60)      r.rssi_threshold = 8'($urandom_range(0, 40));
    else if (pick < 80) r.rssi_threshold = 8'd0;
    else                r.rssi_threshold = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic void plan_cfg(logic [7:0] s, logic [7:0] u, logic [7:0] l,
                                   logic [7:0] t);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.regs = cfg_t'{s, u, l, t};
    plan_q.push_back(row);
  endfunction

  function automatic void plan_item(logic cmd, logic [7:0] rssi, logic failed);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.item = in_item_t'{cmd, rssi, failed};
    plan_q.push_back(row);
  endfunction

  function automatic void plan_fixed(logic cmd, logic [7:0] rssi, logic failed,
                                     logic [7:0] tune, logic scan, logic fin,
                                     logic [7:0] pick);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_FIXED;
    row.item = in_item_t'{cmd, rssi, failed};
    row.want = out_item_t'{tune, scan, fin, pick};
    plan_q.push_back(row);
  endfunction

  // gap after an item; valid drops only when a gap really follows
  task automatic sender_gap();
    int g;
    if (fast_phase) return;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // present one item, hold it until taken, then record what should come back
  task automatic offer(input in_item_t it, input bit pinned, input out_item_t pinned_val);
    out_item_t want;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(it.cmd == CMD_MEASURE && !scan_on)) live_items++;
    want = predict_scan(it);
    result_q.push_back(pinned ? pinned_val : want);
    items_sent++;
    sender_gap();
  endtask

  // register writes only with the block drained
  task automatic write_regs(input cfg_t r);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_ADDR_W-1:0] idx  [4];
    int                    k;
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    vals = '{r.start_channel, r.upper_channel, r.lower_channel, r.rssi_threshold};
    idx  = '{REG_START, REG_UPPER, REG_LOWER, REG_THRESHOLD};
    for (k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    scan_regs = r;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // ---- result checker: sampled at the edge, before this edge's updates ----
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.finished) scans_done++;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, expected none, got %h",
                 $time, out_data);
      end else begin
        want = result_q.pop_front();
        check_field("tune_channel", want.tune_channel, out_data.tune_channel);
        check_field("scanning", 8'(want.scanning), 8'(out_data.scanning));
        check_field("finished", 8'(want.finished), 8'(out_data.finished));
        check_field("chosen_channel", want.chosen_channel, out_data.chosen_channel);
      end
    end
  end

  // ---- watchdog: cycles in a row with no traffic at all ----
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---- receiver: bursts of ready with random stalls, one long hold-off ----
  initial begin
    int run;
    int g;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_once && results_seen >= HOLD_AFTER && in_valid) begin
        // sender keeps pushing while we hold, so the block backs up
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        run = $urandom_range(1, 30);
        repeat (run) @(posedge clk);
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  // ---- stimulus ----
  initial begin
    cfg_t corner_regs [N_CORNERS];
    cfg_t regs;
    int   live_goal;
    int   quota;
    int   phase;
    int   r;
    int   cut;
    int   k;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_START;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;

    // directed table
    // measurement right after reset: dropped, channel still 0
    plan_fixed(CMD_MEASURE, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0);
    plan_cfg(8'd10, 8'd12, 8'd8, 8'd20);
    plan_fixed(CMD_START, 8'd0, 1'b0, 8'd10, 1'b1, 1'b0, 8'd0);
    plan_item(CMD_MEASURE, 8'd50, 1'b0);
    plan_item(CMD_MEASURE, 8'd0, 1'b1);      // failed reading counts as worst
    plan_item(CMD_MEASURE, 8'd255, 1'b0);    // at upper: jump back and step down
    plan_item(CMD_MEASURE, 8'd40, 1'b0);
    plan_item(CMD_MEASURE, 8'd30, 1'b0);     // lower reached: pick the minimum
    plan_item(CMD_START, 8'd255, 1'b1);
    plan_item(CMD_MEASURE, 8'd100, 1'b0);
    plan_fixed(CMD_START, 8'd0, 1'b0, 8'd10, 1'b1, 1'b0, 8'd0);   // restart mid-scan
    plan_fixed(CMD_MEASURE, 8'd5, 1'b0, 8'd10, 1'b0, 1'b1, 8'd10); // below threshold
    plan_fixed(CMD_MEASURE, 8'd7, 1'b0, 8'd10, 1'b0, 1'b0, 8'd0);  // idle after pick
    // start above upper, threshold zero: parked until the store fills
    plan_cfg(8'd200, 8'd100, 8'd50, 8'd0);
    plan_fixed(CMD_START, 8'd0, 1'b0, 8'd200, 1'b1, 1'b0, 8'd0);
    for (k = 1; k < MAX_SAMPLES; k++)
      plan_fixed(CMD_MEASURE, 8'((k * 37) & 8'hFF), k[0], 8'd200, 1'b1, 1'b0, 8'd0);
    plan_fixed(CMD_MEASURE, 8'd0, 1'b0, 8'd200, 1'b0, 1'b1, 8'd200);

    // corner register settings for the first random phases
    corner_regs[0] = cfg_t'{8'd0,   8'd0,   8'd0,   8'd0};
    corner_regs[1] = cfg_t'{8'hFF,  8'hFF,  8'hFF,  8'hFF};
    corner_regs[2] = cfg_t'{8'd0,   8'hFF,  8'd0,   8'd0};
    corner_regs[3] = cfg_t'{8'hFF,  8'd0,   8'hFF,  8'd0};
    corner_regs[4] = cfg_t'{8'd5,   8'd5,   8'd9,   8'd0};   // parked going down
    corner_regs[5] = cfg_t'{8'd128, 8'd130, 8'd126, 8'hFF};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) begin
      case (plan_q[i].kind)
        ROW_CFG:   write_regs(plan_q[i].regs);
        ROW_ITEM:  offer(plan_q[i].item, 1'b0, '0);
        default:   offer(plan_q[i].item, 1'b1, plan_q[i].want);
      endcase
    end

    // random phases: mostly full scans with random readings, some noise
    live_goal = live_items + RANDOM_ITEMS;
    phase     = 0;
    while (live_items < live_goal) begin
      regs = (phase < N_CORNERS) ? corner_regs[phase] : random_regs();
      write_regs(regs);
      fast_phase = ($urandom_range(0, 3) == 0);
      quota = live_items + $urandom_range(20, 60);
      while (live_items < quota) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          offer(measure_item(), 1'b0, '0);   // stray, dropped when idle
        end else if (r < 10) begin
          offer(start_item(), 1'b0, '0);
        end else begin
          offer(start_item(), 1'b0, '0);
          // now and then cut a scan short so the next start restarts it
          cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : MAX_SAMPLES + 1;
          while (scan_on && cut > 0) begin
            offer(measure_item(), 1'b0, '0);
            cut--;
          end
        end
      end
      phase++;
    end
    fast_phase = 1'b0;

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items over %0d register settings, %0d results checked",
             items_sent, phase + 2, results_seen);
    $display("run: %0d scans ended, %0d of them on the threshold, %0d errors",
             scans_done, early_picks, errors);
    if (errors == 0 && result_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/rcs_pkg.sv
design/rcs_step.sv
design/rssi_channel_scan.sv
tb/tb_rssi_channel_scan.sv
